// File: hdl/pclb_pkg.sv
package pclb_pkg;

   // Sizing of the particle and cell stores.
   localparam int MAX_PARTICLES = 1024;
   localparam int MAX_SIDE      = 64;
   localparam int CELLS         = MAX_SIDE * MAX_SIDE;
   localparam int CELL_AW       = $clog2(CELLS);
   localparam int ID_W          = $clog2(MAX_PARTICLES);
   localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
   localparam int COORD_W       = $clog2(MAX_SIDE);
   localparam int SIDE_W        = $clog2(MAX_SIDE + 1);

   // Queue between the front and back parts.
   localparam int Q_DEPTH = 4;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   // Fixed field widths.
   localparam int POS_W      = 24;
   localparam int INV_W      = 32;
   localparam int GS_W       = 7;
   localparam int WRAP_W     = 4;
   localparam int QUERY_W    = 12;
   localparam int CELL_IDX_W = 12;
   localparam int PID_W      = 10;
   localparam int COUNT_W    = 11;
   localparam int LINK_W     = 10;
   localparam int CSR_W      = 32;
   localparam int CSR_AW     = 2;

   // Q16.8 times Q12.20 gives Q28.28; the integer part is the cell coordinate.
   localparam int PROD_W     = POS_W + INV_W;
   localparam int FRAC_SHIFT = 28;
   localparam int CELL_HI_W  = PROD_W - FRAC_SHIFT;

   // Register reset values.
   localparam logic [GS_W-1:0]   GRID_SIDE_RST   = GS_W'(64);
   localparam logic [INV_W-1:0]  INV_SPACING_RST = INV_W'(1048576);
   localparam logic [WRAP_W-1:0] WRAP_OFFSET_RST = '0;

   typedef enum logic [1:0] {
      OP_CLEAR     = 2'd0,
      OP_INSERT    = 2'd1,
      OP_READ_CELL = 2'd2,
      OP_READ_LINK = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CLAMPED = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_GRID_SIDE   = 2'd0,
      CSR_INV_SPACING = 2'd1,
      CSR_WRAP_OFFSET = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_INIT,
      BK_IDLE,
      BK_EXEC,
      BK_CLEAR
   } back_state_type;

   typedef struct packed {
      op_type               op;
      logic [POS_W-1:0]     pos_x;
      logic [POS_W-1:0]     pos_y;
      logic [QUERY_W-1:0]   query_index;
   } req_type;

   typedef struct packed {
      logic [CELL_IDX_W-1:0] cell_index;
      logic [PID_W-1:0]      particle_id;
      logic [PID_W-1:0]      linked_after;
      logic                  has_predecessor;
      logic [COUNT_W-1:0]    count;
      logic [LINK_W-1:0]     link_value;
      logic                  link_valid;
      status_type            status;
   } rsp_type;

   typedef struct packed {
      logic [GS_W-1:0]   grid_side;
      logic [INV_W-1:0]  inv_spacing;
      logic [WRAP_W-1:0] wrap_offset;
   } cfg_type;

   // One classified word waiting for the back part.
   typedef struct packed {
      op_type              op;
      logic [CELL_AW-1:0]  cell_addr;
      logic [QUERY_W-1:0]  query;
      logic                clamped;
   } qentry_type;

   typedef struct packed {
      logic       valid;
      qentry_type entry;
   } push_type;

   typedef struct packed {
      logic              not_empty;
      logic [QCNT_W-1:0] count;
      qentry_type        head;
   } qstat_type;

   // Per-cell memory word.
   typedef struct packed {
      logic             head_valid;
      logic [ID_W-1:0]  head;
      logic [ID_W-1:0]  tail;
      logic [CNT_W-1:0] count;
   } cell_word_type;

   // Per-particle link word.
   typedef struct packed {
      logic            valid;
      logic [ID_W-1:0] next;
   } next_word_type;

endpackage

// File: hdl/pclb_ram.sv
module pclb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/pclb_front.sv
module pclb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  pclb_pkg::req_type   req_data,
   input  pclb_pkg::cfg_type   cfg,
   input  pclb_pkg::qstat_type q_stat,
   input  logic                clearing,
   output logic                busy,
   output pclb_pkg::push_type  push
);
   import pclb_pkg::*;

   localparam int IF_W = QCNT_W + 1;

   logic                   accept;
   logic [IF_W-1:0]        inflight;
   logic [PROD_W-1:0]      prod_x;
   logic [PROD_W-1:0]      prod_y;
   logic                   s1_v_ff;
   op_type                 s1_op_ff;
   logic [QUERY_W-1:0]     s1_query_ff;
   logic [CELL_HI_W-1:0]   s1_x_ff;
   logic [CELL_HI_W-1:0]   s1_x_in;
   logic [CELL_HI_W-1:0]   s1_y_ff;
   logic [CELL_HI_W-1:0]   s1_y_in;
   logic [SIDE_W-1:0]      side;
   logic [COORD_W:0]       x_res;
   logic [COORD_W:0]       y_res;
   logic                   s2_v_ff;
   qentry_type             s2_entry_ff;
   qentry_type             s2_entry_in;

   // Adds the wrap offset and saturates to the last cell; the top bit flags saturation.
   function automatic logic [COORD_W:0] to_coord(
      input logic [CELL_HI_W-1:0] hi,
      input logic [WRAP_W-1:0]    wrap,
      input logic [SIDE_W-1:0]    sd
   );
      logic [CELL_HI_W:0] c;
      logic [CELL_HI_W:0] lim;
      c   = {1'b0, hi} + (CELL_HI_W + 1)'(wrap);
      lim = (CELL_HI_W + 1)'(sd) - (CELL_HI_W + 1)'(1);
      if (c > lim) begin
         return {1'b1, COORD_W'(lim)};
      end
      return {1'b0, COORD_W'(c)};
   endfunction

   // Every word in the two stages or in the queue holds a queue slot.
   assign inflight = IF_W'(s1_v_ff) + IF_W'(s2_v_ff) + IF_W'(q_stat.count);
   assign busy     = clearing || (inflight >= IF_W'(Q_DEPTH));
   assign accept   = start && !busy;

   // Stage one: the two position products.
   assign prod_x  = PROD_W'(req_data.pos_x) * PROD_W'(cfg.inv_spacing);
   assign prod_y  = PROD_W'(req_data.pos_y) * PROD_W'(cfg.inv_spacing);
   assign s1_x_in = prod_x[PROD_W-1:FRAC_SHIFT];
   assign s1_y_in = prod_y[PROD_W-1:FRAC_SHIFT];

   // Side in use: zero acts as one, oversize acts as the store side.
   always_comb begin
      if (cfg.grid_side == '0) begin
         side = SIDE_W'(1);
      end else if (int'(cfg.grid_side) > MAX_SIDE) begin
         side = SIDE_W'(MAX_SIDE);
      end else begin
         side = SIDE_W'(cfg.grid_side);
      end
   end

   // Stage two: clamp the coordinates and form the cell index.
   assign x_res = to_coord(s1_x_ff, cfg.wrap_offset, side);
   assign y_res = to_coord(s1_y_ff, cfg.wrap_offset, side);

   always_comb begin
      s2_entry_in.op        = s1_op_ff;
      s2_entry_in.query     = s1_query_ff;
      s2_entry_in.clamped   = x_res[COORD_W] || y_res[COORD_W];
      s2_entry_in.cell_addr = CELL_AW'(x_res[COORD_W-1:0]) * CELL_AW'(side)
                            + CELL_AW'(y_res[COORD_W-1:0]);
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= accept;
         s2_v_ff <= s1_v_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_data.op;
         s1_query_ff <= req_data.query_index;
         s1_x_ff     <= s1_x_in;
         s1_y_ff     <= s1_y_in;
      end
      s2_entry_ff <= s2_entry_in;
   end

   assign push.valid = s2_v_ff;
   assign push.entry = s2_entry_ff;

endmodule

// File: hdl/pclb_queue.sv
module pclb_queue (
   input  logic                clock,
   input  logic                reset,
   input  pclb_pkg::push_type  push,
   input  logic                pop,
   output pclb_pkg::qstat_type q_stat
);
   import pclb_pkg::*;

   qentry_type        slots_ff [Q_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(Q_DEPTH - 1)) begin
         return '0;
      end
      return p + QPTR_W'(1);
   endfunction

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push.valid ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push.valid) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         slots_ff[wr_ptr_ff] <= push.entry;
      end
   end

   assign q_stat.not_empty = (count_ff != '0);
   assign q_stat.count     = count_ff;
   assign q_stat.head      = slots_ff[rd_ptr_ff];

   // The front part's slot accounting must never overfill the queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (count_ff < QCNT_W'(Q_DEPTH)))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue read while empty");

endmodule

// File: hdl/pclb_back.sv
module pclb_back (
   input  logic                clock,
   input  logic                reset,
   input  pclb_pkg::qstat_type q_stat,
   output logic                pop,
   output logic                clearing,
   output logic                rsp_strobe,
   output pclb_pkg::rsp_type   rsp_data
);
   import pclb_pkg::*;

   back_state_type      state_ff;
   back_state_type      state_in;
   logic [CELL_AW-1:0]  sweep_ff;
   logic [CELL_AW-1:0]  sweep_in;
   logic [CNT_W-1:0]    total_ff;
   logic [CNT_W-1:0]    total_in;
   qentry_type          cur_ff;
   qentry_type          cur_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic                full;
   logic [ID_W-1:0]     new_id;
   cell_word_type       cell_new;

   logic                cell_we;
   logic [CELL_AW-1:0]  cell_waddr;
   cell_word_type       cell_wdata;
   logic [CELL_AW-1:0]  cell_raddr;
   cell_word_type       cell_rdata;
   logic                next_we;
   logic [ID_W-1:0]     next_waddr;
   next_word_type       next_wdata;
   logic [ID_W-1:0]     next_raddr;
   next_word_type       next_rdata;

   pclb_ram #(
      .WIDTH ($bits(cell_word_type)),
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (cell_waddr),
      .wdata (cell_wdata),
      .raddr (cell_raddr),
      .rdata (cell_rdata)
   );

   pclb_ram #(
      .WIDTH ($bits(next_word_type)),
      .DEPTH (MAX_PARTICLES)
   ) u_next_ram (
      .clock (clock),
      .we    (next_we),
      .waddr (next_waddr),
      .wdata (next_wdata),
      .raddr (next_raddr),
      .rdata (next_rdata)
   );

   assign full     = (total_ff == CNT_W'(MAX_PARTICLES));
   assign new_id   = ID_W'(total_ff);
   assign clearing = (state_ff == BK_INIT);

   // Sequencer: pop a word, read the stores, write back and respond, or sweep.
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      total_in     = total_ff;
      cur_in       = cur_ff;
      pop          = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      cell_new     = cell_rdata;
      cell_we      = 1'b0;
      cell_waddr   = sweep_ff;
      cell_wdata   = '0;
      cell_raddr   = (q_stat.head.op == OP_READ_CELL) ? CELL_AW'(q_stat.head.query)
                                                      : q_stat.head.cell_addr;
      next_we      = 1'b0;
      next_waddr   = new_id;
      next_wdata   = '0;
      next_raddr   = ID_W'(q_stat.head.query);

      unique case (state_ff) inside
         BK_INIT, BK_CLEAR: begin
            // Sweep every cell word back to empty.
            cell_we  = 1'b1;
            sweep_in = sweep_ff + CELL_AW'(1);
            if (sweep_ff == CELL_AW'(CELLS - 1)) begin
               state_in = BK_IDLE;
               sweep_in = '0;
               if (state_ff == BK_CLEAR) begin
                  total_in     = '0;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         BK_IDLE: begin
            if (q_stat.not_empty) begin
               pop    = 1'b1;
               cur_in = q_stat.head;
               if (q_stat.head.op == OP_CLEAR) begin
                  state_in = BK_CLEAR;
               end else begin
                  state_in = BK_EXEC;
                  // A new particle starts as the end of its chain.
                  if (q_stat.head.op == OP_INSERT && !full) begin
                     next_we = 1'b1;
                  end
               end
            end
         end
         BK_EXEC: begin
            state_in     = BK_IDLE;
            rsp_valid_in = 1'b1;
            unique case (cur_ff.op)
               OP_INSERT: begin
                  rsp_in.cell_index = CELL_IDX_W'(cur_ff.cell_addr);
                  if (full) begin
                     rsp_in.count  = COUNT_W'(cell_rdata.count);
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     if (cell_rdata.head_valid) begin
                        // Link the old tail to the new particle.
                        next_we                = 1'b1;
                        next_waddr             = cell_rdata.tail;
                        next_wdata.valid       = 1'b1;
                        next_wdata.next        = new_id;
                        rsp_in.linked_after    = PID_W'(cell_rdata.tail);
                        rsp_in.has_predecessor = 1'b1;
                     end else begin
                        cell_new.head_valid = 1'b1;
                        cell_new.head       = new_id;
                     end
                     cell_new.tail      = new_id;
                     cell_new.count     = cell_rdata.count + CNT_W'(1);
                     cell_we            = 1'b1;
                     cell_waddr         = cur_ff.cell_addr;
                     cell_wdata         = cell_new;
                     total_in           = total_ff + CNT_W'(1);
                     rsp_in.particle_id = PID_W'(new_id);
                     rsp_in.count       = COUNT_W'(cell_new.count);
                     rsp_in.status      = cur_ff.clamped ? STATUS_CLAMPED : STATUS_OK;
                  end
               end
               OP_READ_CELL: begin
                  rsp_in.cell_index = CELL_IDX_W'(cur_ff.query);
                  if (int'(cur_ff.query) < CELLS) begin
                     rsp_in.count = COUNT_W'(cell_rdata.count);
                     if (cell_rdata.head_valid) begin
                        rsp_in.link_value = LINK_W'(cell_rdata.head);
                        rsp_in.link_valid = 1'b1;
                     end
                  end
               end
               OP_READ_LINK: begin
                  if (int'(cur_ff.query) < int'(total_ff) && next_rdata.valid) begin
                     rsp_in.link_value = LINK_W'(next_rdata.next);
                     rsp_in.link_valid = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Control state; the reset starts the sweep of the cell store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_INIT;
         sweep_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // A word is only delivered after an execute step or the end of a clear sweep.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff == BK_EXEC) || $past(state_ff == BK_CLEAR)))
      else $error("response without a finished operation");

   // An insert into a full store must not change the particle count.
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EXEC && cur_ff.op == OP_INSERT && full) |=> $stable(total_ff))
      else $error("particle count moved on a dropped insert");

   // The end of a clear sweep empties the store and responds.
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR && sweep_ff == CELL_AW'(CELLS - 1))
      |=> (total_ff == '0 && rsp_valid_ff))
      else $error("clear finished without reset count or response");

endmodule

// File: hdl/particle_cell_list_binner.sv
// Particle cell-list binner.
// Input words are offered on req_data with start and are taken at a clock edge where
// start is high and busy is low. Result words appear on rsp_data for exactly one cycle,
// marked by rsp_strobe; every input word gives exactly one result word, in order.
// Configuration registers (grid side, inverse spacing, wrap offset) are written through
// csr_we/csr_index/csr_wdata and act once registered; write them only while idle.
// A front part computes the cell index over two registered stages (the position
// products, then clamp and index), and hands words through a four-entry queue to a
// back part that owns the cell and link memories.
// With an empty queue, a word passes both front stages, the queue, the back idle and
// execute states and the response register before rsp_strobe. An insert or read takes
// an idle step (pop, memory read) and an execute step (write-back, response), as the cell
// memory has a registered read port; the back part takes no new word before the last is
// done. A clear sweeps all 4096 cell words, one per cycle, and responds when the sweep
// ends. After reset the same sweep runs with busy high; configuration writes are taken
// during it. The receiver cannot stall: results come even if nobody watches rsp_strobe.
module particle_cell_list_binner (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  pclb_pkg::req_type                 req_data,
   output logic                              rsp_strobe,
   output pclb_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [pclb_pkg::CSR_AW-1:0]       csr_index,
   input  logic [pclb_pkg::CSR_W-1:0]        csr_wdata
);
   import pclb_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   push_type  push;
   qstat_type q_stat;
   logic      pop;
   logic      clearing;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GRID_SIDE:   cfg_in.grid_side   = GS_W'(csr_wdata);
            CSR_INV_SPACING: cfg_in.inv_spacing = INV_W'(csr_wdata);
            CSR_WRAP_OFFSET: cfg_in.wrap_offset = WRAP_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_side   <= GRID_SIDE_RST;
         cfg_ff.inv_spacing <= INV_SPACING_RST;
         cfg_ff.wrap_offset <= WRAP_OFFSET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pclb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .q_stat   (q_stat),
      .clearing (clearing),
      .busy     (busy),
      .push     (push)
   );

   pclb_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .q_stat (q_stat)
   );

   pclb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
